// ===== src/cwc_pkg.sv =====
// Shared types, constants and the MAC sequence table for the window coherence block.
`default_nettype none
package cwc_pkg;

    localparam int MAX_WINDOW_DEF  = 9;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_W           = 4;
    localparam int COORD_W         = 12;
    localparam int COH_W           = 16;
    localparam int UNITY_SHIFT     = 30;
    localparam int QUOT_W          = 31;
    localparam int ROOT_W          = 16;
    localparam int SQRT_STEPS      = 16;
    localparam int OP_W            = 4;

    localparam logic [CFG_W-1:0] WINDOW_RESET = 4'd5;
    localparam logic [OP_W-1:0]  LAST_OP      = 4'd14;
    localparam logic [COH_W-1:0] COH_UNITY    = 16'd32768;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_P2_INIT,
        ST_P2_ADDR,
        ST_P2_MUL,
        ST_P2_FLUSH,
        ST_MAC_GO,
        ST_MAC_WAIT,
        ST_DIV_INIT,
        ST_DIV,
        ST_SQRT_INIT,
        ST_SQRT,
        ST_OUTPUT
    } state_t;

    typedef enum logic [2:0] {
        PH_CUR_RR,
        PH_CUR_II,
        PH_REF_RR,
        PH_REF_II,
        PH_X_RR,
        PH_X_II,
        PH_X_RI,
        PH_X_IR
    } mul_phase_t;

    typedef enum logic [3:0] {
        SRC_N,
        SRC_CR,
        SRC_CI,
        SRC_PFF,
        SRC_PGG,
        SRC_SCR,
        SRC_SCI,
        SRC_SRR,
        SRC_SRI,
        SRC_NR,
        SRC_NI,
        SRC_D1,
        SRC_D2
    } src_t;

    typedef enum logic [2:0] {
        DST_NONE,
        DST_NR,
        DST_NI,
        DST_D1,
        DST_D2,
        DST_M,
        DST_D
    } dst_t;

    typedef struct packed {
        src_t a;
        src_t b;
        logic clr;
        logic sub;
        dst_t dst;
    } mac_op_t;

    typedef struct packed {
        logic       in_ready;
        logic       acc_clr;
        logic       rd;
        logic       mul_en;
        mul_phase_t phase;
        logic       mac_start;
        logic       mac_store;
        mac_op_t    op;
        logic       div_init;
        logic       div_step;
        logic       sqrt_init;
        logic       sqrt_step;
        logic       emit;
    } ctrl_cmd_t;

    typedef struct packed {
        logic mac_busy;
        logic out_free;
    } dp_status_t;

    // Window-end sequence: cross terms, energies, |num|^2, den1*den2.
    function automatic mac_op_t mac_op(input logic [OP_W-1:0] idx);
        mac_op_t op;
        op = '{SRC_N, SRC_N, 1'b1, 1'b0, DST_NONE};
        case (idx)
            4'd0:    op = '{SRC_N,   SRC_CR,  1'b1, 1'b0, DST_NONE};
            4'd1:    op = '{SRC_SCR, SRC_SRR, 1'b0, 1'b1, DST_NONE};
            4'd2:    op = '{SRC_SCI, SRC_SRI, 1'b0, 1'b1, DST_NR};
            4'd3:    op = '{SRC_N,   SRC_CI,  1'b1, 1'b0, DST_NONE};
            4'd4:    op = '{SRC_SCR, SRC_SRI, 1'b0, 1'b1, DST_NONE};
            4'd5:    op = '{SRC_SCI, SRC_SRR, 1'b0, 1'b0, DST_NI};
            4'd6:    op = '{SRC_N,   SRC_PFF, 1'b1, 1'b0, DST_NONE};
            4'd7:    op = '{SRC_SCR, SRC_SCR, 1'b0, 1'b1, DST_NONE};
            4'd8:    op = '{SRC_SCI, SRC_SCI, 1'b0, 1'b1, DST_D1};
            4'd9:    op = '{SRC_N,   SRC_PGG, 1'b1, 1'b0, DST_NONE};
            4'd10:   op = '{SRC_SRR, SRC_SRR, 1'b0, 1'b1, DST_NONE};
            4'd11:   op = '{SRC_SRI, SRC_SRI, 1'b0, 1'b1, DST_D2};
            4'd12:   op = '{SRC_NR,  SRC_NR,  1'b1, 1'b0, DST_NONE};
            4'd13:   op = '{SRC_NI,  SRC_NI,  1'b0, 1'b0, DST_M};
            4'd14:   op = '{SRC_D1,  SRC_D2,  1'b1, 1'b0, DST_D};
            default: op = '{SRC_N,   SRC_N,   1'b1, 1'b0, DST_NONE};
        endcase
        return op;
    endfunction

endpackage
`default_nettype wire

// ===== src/complex_window_coherence_top.sv =====
// Top level of the complex window coherence block.
//
//   channel | signals                                   | handshake
//   --------+-------------------------------------------+--------------------------
//   cfg     | cfg_we, cfg_data                          | write when cfg_we high
//   in      | cur_*, ref_*, window_*, last_sample       | in_valid / in_ready
//   out     | coherence, center_row, center_col         | out_valid / out_ready
//
// A sample request is taken whenever it is offered while the window loads.
// The flagged request then starts a second pass over the n stored samples, eight
// products a sample on one multiplier, followed by fifteen serial MAC operations of
// EW+1 steps, XW divide steps and sixteen root steps.
// Reset clears the sums, count and control; no clearing pass is run.
// A pending result does not block loading of the next window.
`default_nettype none
module complex_window_coherence_top #(
    parameter int MAX_WINDOW  = cwc_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = cwc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_we,
    input  wire logic [cwc_pkg::CFG_W-1:0]     cfg_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic signed [SAMPLE_BITS-1:0] cur_real,
    input  wire logic signed [SAMPLE_BITS-1:0] cur_imag,
    input  wire logic signed [SAMPLE_BITS-1:0] ref_real,
    input  wire logic signed [SAMPLE_BITS-1:0] ref_imag,
    input  wire logic [cwc_pkg::COORD_W-1:0]   window_row,
    input  wire logic [cwc_pkg::COORD_W-1:0]   window_col,
    input  wire logic                          last_sample,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [cwc_pkg::COH_W-1:0]          coherence,
    output logic [cwc_pkg::COORD_W-1:0]        center_row,
    output logic [cwc_pkg::COORD_W-1:0]        center_col
);

    localparam int N  = MAX_WINDOW * MAX_WINDOW;
    localparam int IW = (N > 1) ? $clog2(N) : 1;
    localparam int CW = $clog2(N + 1);

    cwc_pkg::ctrl_cmd_t  cmd;
    cwc_pkg::dp_status_t status;
    logic [IW-1:0]       raddr;
    logic [CW-1:0]       count;
    logic                in_accept;

    assign in_ready  = cmd.in_ready;
    assign in_accept = in_valid && cmd.in_ready;

    cwc_ctrl #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_accept   (in_accept),
        .last_sample (last_sample),
        .status      (status),
        .count       (count),
        .cmd         (cmd),
        .raddr       (raddr)
    );

    cwc_datapath #(
        .MAX_WINDOW  (MAX_WINDOW),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .raddr       (raddr),
        .count       (count),
        .cfg_we      (cfg_we),
        .cfg_data    (cfg_data),
        .in_accept   (in_accept),
        .cur_real    (cur_real),
        .cur_imag    (cur_imag),
        .ref_real    (ref_real),
        .ref_imag    (ref_imag),
        .window_row  (window_row),
        .window_col  (window_col),
        .last_sample (last_sample),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .coherence   (coherence),
        .center_row  (center_row),
        .center_col  (center_col)
    );

endmodule
`default_nettype wire

// ===== src/cwc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module cwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 81
) (
    input  wire logic                                   clk,
    input  wire logic                                   we,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  wire logic [WIDTH-1:0]                       wdata,
    input  wire logic                                   re,
    input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic      [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

// ===== src/cwc_mac.sv =====
// Shift-add serial multiply-accumulate unit for the window-end arithmetic.
`default_nettype none
module cwc_mac #(
    parameter int EW = 48
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    input  wire logic                   clr,
    input  wire logic                   sub,
    input  wire logic signed [EW-1:0]   a,
    input  wire logic signed [EW-1:0]   b,
    output logic                        busy,
    output logic signed [2*EW+1:0]      acc
);

    localparam int ACCW = 2 * EW + 2;
    localparam int CNTW = $clog2(EW + 1);

    logic                   busy_reg;
    logic [CNTW-1:0]        cnt_reg;
    logic [2*EW-1:0]        ma_reg;
    logic [EW-1:0]          mb_reg;
    logic [2*EW-1:0]        prod_reg;
    logic                   neg_reg;
    logic signed [ACCW-1:0] acc_reg;
    logic [EW-1:0]          abs_a;
    logic [EW-1:0]          abs_b;
    logic signed [ACCW-1:0] prod_ext;

    assign abs_a    = a[EW-1] ? (~a + 1'b1) : a;
    assign abs_b    = b[EW-1] ? (~b + 1'b1) : b;
    assign prod_ext = $signed({2'b00, prod_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= CNTW'(EW);
        end
        else if (busy_reg)
        begin
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
            end
            else
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            ma_reg   <= {{EW{1'b0}}, abs_a};
            mb_reg   <= abs_b;
            prod_reg <= '0;
            neg_reg  <= a[EW-1] ^ b[EW-1] ^ sub;
            if (clr)
            begin
                acc_reg <= '0;
            end
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                if (mb_reg[0])
                begin
                    prod_reg <= prod_reg + ma_reg;
                end
                ma_reg <= ma_reg << 1;
                mb_reg <= mb_reg >> 1;
            end
            else
            begin
                acc_reg <= neg_reg ? (acc_reg - prod_ext) : (acc_reg + prod_ext);
            end
        end
    end

    assign busy = busy_reg;
    assign acc  = acc_reg;

endmodule
`default_nettype wire

// ===== src/cwc_datapath.sv =====
// Datapath: window stores, sums, second-pass accumulators, MAC, divider and root.
`default_nettype none
module cwc_datapath #(
    parameter int MAX_WINDOW  = cwc_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = cwc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire cwc_pkg::ctrl_cmd_t                  cmd,
    output cwc_pkg::dp_status_t                      status,
    input  wire logic [((MAX_WINDOW*MAX_WINDOW) > 1 ?
                        $clog2(MAX_WINDOW*MAX_WINDOW) : 1)-1:0] raddr,
    output logic [$clog2(MAX_WINDOW*MAX_WINDOW+1)-1:0] count,
    input  wire logic                                cfg_we,
    input  wire logic [cwc_pkg::CFG_W-1:0]           cfg_data,
    input  wire logic                                in_accept,
    input  wire logic signed [SAMPLE_BITS-1:0]       cur_real,
    input  wire logic signed [SAMPLE_BITS-1:0]       cur_imag,
    input  wire logic signed [SAMPLE_BITS-1:0]       ref_real,
    input  wire logic signed [SAMPLE_BITS-1:0]       ref_imag,
    input  wire logic [cwc_pkg::COORD_W-1:0]         window_row,
    input  wire logic [cwc_pkg::COORD_W-1:0]         window_col,
    input  wire logic                                last_sample,
    output logic                                     out_valid,
    input  wire logic                                out_ready,
    output logic [cwc_pkg::COH_W-1:0]                coherence,
    output logic [cwc_pkg::COORD_W-1:0]              center_row,
    output logic [cwc_pkg::COORD_W-1:0]              center_col
);

    localparam int B    = SAMPLE_BITS;
    localparam int N    = MAX_WINDOW * MAX_WINDOW;
    localparam int IW   = (N > 1) ? $clog2(N) : 1;
    localparam int CW   = $clog2(N + 1);
    localparam int SW   = B + CW;
    localparam int PW   = 2 * B;
    localparam int AW   = 2 * B + CW + 1;
    localparam int EW   = 2 * B + 2 * CW + 2;
    localparam int ACCW = 2 * EW + 2;
    localparam int DW   = 2 * EW + 1;
    localparam int XW   = DW + cwc_pkg::UNITY_SHIFT;
    localparam int RW   = cwc_pkg::ROOT_W;

    logic [cwc_pkg::CFG_W-1:0]   window_size_reg;
    logic signed [SW-1:0]        sum_cr_reg;
    logic signed [SW-1:0]        sum_ci_reg;
    logic signed [SW-1:0]        sum_rr_reg;
    logic signed [SW-1:0]        sum_ri_reg;
    logic [CW-1:0]               count_reg;
    logic [cwc_pkg::COORD_W-1:0] crow_reg;
    logic [cwc_pkg::COORD_W-1:0] ccol_reg;
    logic [cwc_pkg::COORD_W-1:0] half;
    logic                        store_ok;

    logic [2*B-1:0]              cur_rd;
    logic [2*B-1:0]              ref_rd;
    logic signed [B-1:0]         fr;
    logic signed [B-1:0]         fi;
    logic signed [B-1:0]         gr;
    logic signed [B-1:0]         gi;
    logic signed [B-1:0]         mul_a;
    logic signed [B-1:0]         mul_b;
    logic signed [PW-1:0]        prod_reg;
    cwc_pkg::mul_phase_t         prod_ph_reg;
    logic                        prod_vld_reg;
    logic signed [AW-1:0]        prod_ext;
    logic signed [AW-1:0]        pff_reg;
    logic signed [AW-1:0]        pgg_reg;
    logic signed [AW-1:0]        cr_reg;
    logic signed [AW-1:0]        ci_reg;

    logic signed [EW-1:0]        mac_a;
    logic signed [EW-1:0]        mac_b;
    logic                        mac_busy;
    logic signed [ACCW-1:0]      mac_acc;
    logic signed [EW-1:0]        nr_reg;
    logic signed [EW-1:0]        ni_reg;
    logic signed [EW-1:0]        d1_reg;
    logic signed [EW-1:0]        d2_reg;
    logic [DW-1:0]               m_reg;
    logic [DW-1:0]               d_reg;

    logic [XW-1:0]               x_reg;
    logic [DW-1:0]               rem_reg;
    logic [cwc_pkg::QUOT_W-1:0]  quot_reg;
    logic [DW:0]                 div_t;
    logic [DW:0]                 div_diff;
    logic                        div_ge;

    logic [2*RW-1:0]             sq_src_reg;
    logic [RW:0]                 srem_reg;
    logic [RW-1:0]               root_reg;
    logic [RW+1:0]               sq_t;
    logic [RW+1:0]               sq_trial;
    logic [RW+1:0]               sq_diff;
    logic                        sq_ge;

    logic                        out_valid_reg;
    logic [cwc_pkg::COH_W-1:0]   coh_out_reg;
    logic [cwc_pkg::COORD_W-1:0] row_out_reg;
    logic [cwc_pkg::COORD_W-1:0] col_out_reg;

    assign half     = cwc_pkg::COORD_W'(window_size_reg >> 1);
    assign store_ok = count_reg < CW'(N);

    cwc_ram #(.WIDTH(2 * B), .DEPTH(N)) u_cur_ram (
        .clk   (clk),
        .we    (in_accept && store_ok),
        .waddr (count_reg[IW-1:0]),
        .wdata ({cur_real, cur_imag}),
        .re    (cmd.rd),
        .raddr (raddr),
        .rdata (cur_rd)
    );

    cwc_ram #(.WIDTH(2 * B), .DEPTH(N)) u_ref_ram (
        .clk   (clk),
        .we    (in_accept && store_ok),
        .waddr (count_reg[IW-1:0]),
        .wdata ({ref_real, ref_imag}),
        .re    (cmd.rd),
        .raddr (raddr),
        .rdata (ref_rd)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_size_reg <= cwc_pkg::WINDOW_RESET;
        end
        else if (cfg_we)
        begin
            window_size_reg <= cfg_data;
        end
    end

    // Window load: store and sum, drop pairs past capacity.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_cr_reg <= '0;
            sum_ci_reg <= '0;
            sum_rr_reg <= '0;
            sum_ri_reg <= '0;
            count_reg  <= '0;
        end
        else if (cmd.emit)
        begin
            sum_cr_reg <= '0;
            sum_ci_reg <= '0;
            sum_rr_reg <= '0;
            sum_ri_reg <= '0;
            count_reg  <= '0;
        end
        else if (in_accept && store_ok)
        begin
            sum_cr_reg <= sum_cr_reg + SW'(cur_real);
            sum_ci_reg <= sum_ci_reg + SW'(cur_imag);
            sum_rr_reg <= sum_rr_reg + SW'(ref_real);
            sum_ri_reg <= sum_ri_reg + SW'(ref_imag);
            count_reg  <= count_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && last_sample)
        begin
            crow_reg <= window_row + half;
            ccol_reg <= window_col + half;
        end
    end

    assign fr = cur_rd[2*B-1:B];
    assign fi = cur_rd[B-1:0];
    assign gr = ref_rd[2*B-1:B];
    assign gi = ref_rd[B-1:0];

    always_comb
    begin
        case (cmd.phase)
            cwc_pkg::PH_CUR_RR: begin mul_a = fr; mul_b = fr; end
            cwc_pkg::PH_CUR_II: begin mul_a = fi; mul_b = fi; end
            cwc_pkg::PH_REF_RR: begin mul_a = gr; mul_b = gr; end
            cwc_pkg::PH_REF_II: begin mul_a = gi; mul_b = gi; end
            cwc_pkg::PH_X_RR:   begin mul_a = fr; mul_b = gr; end
            cwc_pkg::PH_X_II:   begin mul_a = fi; mul_b = gi; end
            cwc_pkg::PH_X_RI:   begin mul_a = fr; mul_b = gi; end
            cwc_pkg::PH_X_IR:   begin mul_a = fi; mul_b = gr; end
            default:            begin mul_a = fr; mul_b = fr; end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prod_vld_reg <= 1'b0;
        end
        else
        begin
            prod_vld_reg <= cmd.mul_en;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg    <= mul_a * mul_b;
        prod_ph_reg <= cmd.phase;
    end

    assign prod_ext = AW'(prod_reg);

    // Second pass: energies and cross product over the stored window.
    always_ff @(posedge clk)
    begin
        if (cmd.acc_clr)
        begin
            pff_reg <= '0;
            pgg_reg <= '0;
            cr_reg  <= '0;
            ci_reg  <= '0;
        end
        else if (prod_vld_reg)
        begin
            case (prod_ph_reg)
                cwc_pkg::PH_CUR_RR,
                cwc_pkg::PH_CUR_II: pff_reg <= pff_reg + prod_ext;
                cwc_pkg::PH_REF_RR,
                cwc_pkg::PH_REF_II: pgg_reg <= pgg_reg + prod_ext;
                cwc_pkg::PH_X_RR,
                cwc_pkg::PH_X_II:   cr_reg  <= cr_reg + prod_ext;
                cwc_pkg::PH_X_RI:   ci_reg  <= ci_reg + prod_ext;
                cwc_pkg::PH_X_IR:   ci_reg  <= ci_reg - prod_ext;
                default:            pff_reg <= pff_reg;
            endcase
        end
    end

    always_comb
    begin
        case (cmd.op.a)
            cwc_pkg::SRC_N:   mac_a = $signed({{(EW-CW){1'b0}}, count_reg});
            cwc_pkg::SRC_CR:  mac_a = EW'(cr_reg);
            cwc_pkg::SRC_CI:  mac_a = EW'(ci_reg);
            cwc_pkg::SRC_PFF: mac_a = EW'(pff_reg);
            cwc_pkg::SRC_PGG: mac_a = EW'(pgg_reg);
            cwc_pkg::SRC_SCR: mac_a = EW'(sum_cr_reg);
            cwc_pkg::SRC_SCI: mac_a = EW'(sum_ci_reg);
            cwc_pkg::SRC_SRR: mac_a = EW'(sum_rr_reg);
            cwc_pkg::SRC_SRI: mac_a = EW'(sum_ri_reg);
            cwc_pkg::SRC_NR:  mac_a = nr_reg;
            cwc_pkg::SRC_NI:  mac_a = ni_reg;
            cwc_pkg::SRC_D1:  mac_a = d1_reg;
            cwc_pkg::SRC_D2:  mac_a = d2_reg;
            default:          mac_a = '0;
        endcase
    end

    always_comb
    begin
        case (cmd.op.b)
            cwc_pkg::SRC_N:   mac_b = $signed({{(EW-CW){1'b0}}, count_reg});
            cwc_pkg::SRC_CR:  mac_b = EW'(cr_reg);
            cwc_pkg::SRC_CI:  mac_b = EW'(ci_reg);
            cwc_pkg::SRC_PFF: mac_b = EW'(pff_reg);
            cwc_pkg::SRC_PGG: mac_b = EW'(pgg_reg);
            cwc_pkg::SRC_SCR: mac_b = EW'(sum_cr_reg);
            cwc_pkg::SRC_SCI: mac_b = EW'(sum_ci_reg);
            cwc_pkg::SRC_SRR: mac_b = EW'(sum_rr_reg);
            cwc_pkg::SRC_SRI: mac_b = EW'(sum_ri_reg);
            cwc_pkg::SRC_NR:  mac_b = nr_reg;
            cwc_pkg::SRC_NI:  mac_b = ni_reg;
            cwc_pkg::SRC_D1:  mac_b = d1_reg;
            cwc_pkg::SRC_D2:  mac_b = d2_reg;
            default:          mac_b = '0;
        endcase
    end

    cwc_mac #(.EW(EW)) u_mac (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.mac_start),
        .clr   (cmd.op.clr),
        .sub   (cmd.op.sub),
        .a     (mac_a),
        .b     (mac_b),
        .busy  (mac_busy),
        .acc   (mac_acc)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.mac_store)
        begin
            case (cmd.op.dst)
                cwc_pkg::DST_NR:   nr_reg <= mac_acc[EW-1:0];
                cwc_pkg::DST_NI:   ni_reg <= mac_acc[EW-1:0];
                cwc_pkg::DST_D1:   d1_reg <= mac_acc[EW-1:0];
                cwc_pkg::DST_D2:   d2_reg <= mac_acc[EW-1:0];
                cwc_pkg::DST_M:    m_reg  <= mac_acc[DW-1:0];
                cwc_pkg::DST_D:    d_reg  <= mac_acc[DW-1:0];
                default:           m_reg  <= m_reg;
            endcase
        end
    end

    // Restoring divide of |num|^2 * 2^30 by den1*den2, one bit a cycle.
    assign div_t    = {rem_reg, x_reg[XW-1]};
    assign div_diff = div_t - {1'b0, d_reg};
    assign div_ge   = div_t >= {1'b0, d_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            x_reg    <= {m_reg, {cwc_pkg::UNITY_SHIFT{1'b0}}};
            rem_reg  <= '0;
            quot_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            x_reg    <= x_reg << 1;
            rem_reg  <= div_ge ? div_diff[DW-1:0] : div_t[DW-1:0];
            quot_reg <= {quot_reg[cwc_pkg::QUOT_W-2:0], div_ge};
        end
    end

    // Digit-by-digit square root of the quotient, two bits a cycle.
    assign sq_t     = {srem_reg[RW-1:0], sq_src_reg[2*RW-1 -: 2]};
    assign sq_trial = {root_reg, 2'b01};
    assign sq_diff  = sq_t - sq_trial;
    assign sq_ge    = sq_t >= sq_trial;

    always_ff @(posedge clk)
    begin
        if (cmd.sqrt_init)
        begin
            sq_src_reg <= {{(2*RW-cwc_pkg::QUOT_W){1'b0}}, quot_reg};
            srem_reg   <= '0;
            root_reg   <= '0;
        end
        else if (cmd.sqrt_step)
        begin
            sq_src_reg <= sq_src_reg << 2;
            srem_reg   <= sq_ge ? sq_diff[RW:0] : sq_t[RW:0];
            root_reg   <= {root_reg[RW-2:0], sq_ge};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            if ((d1_reg == '0) || (d2_reg == '0))
            begin
                coh_out_reg <= '0;
            end
            else if (root_reg > cwc_pkg::COH_UNITY)
            begin
                coh_out_reg <= cwc_pkg::COH_UNITY;
            end
            else
            begin
                coh_out_reg <= root_reg;
            end
            row_out_reg <= crow_reg;
            col_out_reg <= ccol_reg;
        end
    end

    assign status.mac_busy = mac_busy;
    assign status.out_free = !out_valid_reg || out_ready;
    assign count           = count_reg;
    assign out_valid       = out_valid_reg;
    assign coherence       = coh_out_reg;
    assign center_row      = row_out_reg;
    assign center_col      = col_out_reg;

endmodule
`default_nettype wire

// ===== src/cwc_ctrl.sv =====
// Controller: load, second pass, MAC sequence, divide, root and result handoff.
`default_nettype none
module cwc_ctrl #(
    parameter int MAX_WINDOW  = cwc_pkg::MAX_WINDOW_DEF,
    parameter int SAMPLE_BITS = cwc_pkg::SAMPLE_BITS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                in_accept,
    input  wire logic                                last_sample,
    input  wire cwc_pkg::dp_status_t                 status,
    input  wire logic [$clog2(MAX_WINDOW*MAX_WINDOW+1)-1:0] count,
    output cwc_pkg::ctrl_cmd_t                       cmd,
    output logic [((MAX_WINDOW*MAX_WINDOW) > 1 ?
                   $clog2(MAX_WINDOW*MAX_WINDOW) : 1)-1:0] raddr
);

    localparam int N     = MAX_WINDOW * MAX_WINDOW;
    localparam int IW    = (N > 1) ? $clog2(N) : 1;
    localparam int CW    = $clog2(N + 1);
    localparam int EW    = 2 * SAMPLE_BITS + 2 * CW + 2;
    localparam int XW    = 2 * EW + 1 + cwc_pkg::UNITY_SHIFT;
    localparam int STEPW = $clog2(XW + 1);

    cwc_pkg::state_t          state_reg;
    cwc_pkg::state_t          state_next;
    logic [IW-1:0]            k_reg;
    logic [IW-1:0]            k_next;
    cwc_pkg::mul_phase_t      phase_reg;
    cwc_pkg::mul_phase_t      phase_next;
    logic [cwc_pkg::OP_W-1:0] op_reg;
    logic [cwc_pkg::OP_W-1:0] op_next;
    logic [STEPW-1:0]         step_reg;
    logic [STEPW-1:0]         step_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= cwc_pkg::ST_IDLE;
            k_reg     <= '0;
            phase_reg <= cwc_pkg::PH_CUR_RR;
            op_reg    <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            phase_reg <= phase_next;
            op_reg    <= op_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        phase_next = phase_reg;
        op_next    = op_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.op     = cwc_pkg::mac_op(op_reg);
        cmd.phase  = phase_reg;
        case (state_reg)
            cwc_pkg::ST_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_accept && last_sample)
                begin
                    state_next = cwc_pkg::ST_P2_INIT;
                end
            end
            cwc_pkg::ST_P2_INIT:
            begin
                cmd.acc_clr = 1'b1;
                k_next      = '0;
                phase_next  = cwc_pkg::PH_CUR_RR;
                state_next  = cwc_pkg::ST_P2_ADDR;
            end
            cwc_pkg::ST_P2_ADDR:
            begin
                cmd.rd     = 1'b1;
                state_next = cwc_pkg::ST_P2_MUL;
            end
            cwc_pkg::ST_P2_MUL:
            begin
                cmd.mul_en = 1'b1;
                if (phase_reg == cwc_pkg::PH_X_IR)
                begin
                    phase_next = cwc_pkg::PH_CUR_RR;
                    if ((CW'(k_reg) + CW'(1)) == count)
                    begin
                        state_next = cwc_pkg::ST_P2_FLUSH;
                    end
                    else
                    begin
                        k_next     = k_reg + 1'b1;
                        state_next = cwc_pkg::ST_P2_ADDR;
                    end
                end
                else
                begin
                    phase_next = cwc_pkg::mul_phase_t'(phase_reg + 1'b1);
                end
            end
            cwc_pkg::ST_P2_FLUSH:
            begin
                op_next    = '0;
                state_next = cwc_pkg::ST_MAC_GO;
            end
            cwc_pkg::ST_MAC_GO:
            begin
                cmd.mac_start = 1'b1;
                state_next    = cwc_pkg::ST_MAC_WAIT;
            end
            cwc_pkg::ST_MAC_WAIT:
            begin
                if (!status.mac_busy)
                begin
                    cmd.mac_store = 1'b1;
                    if (op_reg == cwc_pkg::LAST_OP)
                    begin
                        state_next = cwc_pkg::ST_DIV_INIT;
                    end
                    else
                    begin
                        op_next    = op_reg + 1'b1;
                        state_next = cwc_pkg::ST_MAC_GO;
                    end
                end
            end
            cwc_pkg::ST_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
                step_next    = '0;
                state_next   = cwc_pkg::ST_DIV;
            end
            cwc_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (step_reg == STEPW'(XW - 1))
                begin
                    state_next = cwc_pkg::ST_SQRT_INIT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            cwc_pkg::ST_SQRT_INIT:
            begin
                cmd.sqrt_init = 1'b1;
                step_next     = '0;
                state_next    = cwc_pkg::ST_SQRT;
            end
            cwc_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                if (step_reg == STEPW'(cwc_pkg::SQRT_STEPS - 1))
                begin
                    state_next = cwc_pkg::ST_OUTPUT;
                end
                else
                begin
                    step_next = step_reg + 1'b1;
                end
            end
            cwc_pkg::ST_OUTPUT:
            begin
                // hold until the output register frees up
                if (status.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = cwc_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cwc_pkg::ST_IDLE;
            end
        endcase
    end

    assign raddr = k_reg;

endmodule
`default_nettype wire

// ===== src/complex_window_coherence_chk.sv =====
// Port-level checker for the complex window coherence block, with its bind.
`default_nettype none
module complex_window_coherence_chk #(
    parameter int SAMPLE_BITS = cwc_pkg::SAMPLE_BITS_DEF
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cfg_we,
    input wire logic [cwc_pkg::CFG_W-1:0]     cfg_data,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic signed [SAMPLE_BITS-1:0] cur_real,
    input wire logic signed [SAMPLE_BITS-1:0] cur_imag,
    input wire logic signed [SAMPLE_BITS-1:0] ref_real,
    input wire logic signed [SAMPLE_BITS-1:0] ref_imag,
    input wire logic [cwc_pkg::COORD_W-1:0]   window_row,
    input wire logic [cwc_pkg::COORD_W-1:0]   window_col,
    input wire logic                          last_sample,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic [cwc_pkg::COH_W-1:0]     coherence,
    input wire logic [cwc_pkg::COORD_W-1:0]   center_row,
    input wire logic [cwc_pkg::COORD_W-1:0]   center_col
);

    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result valid during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(coherence)
            && $stable(center_row) && $stable(center_col))
        else $error("stalled result changed");

    a_coh_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> coherence <= cwc_pkg::COH_UNITY)
        else $error("coherence above unity");

    a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && last_sample |=> !in_ready)
        else $error("request taken right after window end");

    a_emit_busy: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready))
        else $error("result issued while loading");

endmodule

bind complex_window_coherence_top complex_window_coherence_chk #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_chk (.*);
`default_nettype wire

// ===== tb/tb_top.sv =====
// Self-checking testbench for complex_window_coherence_top: directed and random windows.
module tb_top;

    localparam int CAP = cwc_pkg::MAX_WINDOW_DEF * cwc_pkg::MAX_WINDOW_DEF;

    typedef struct {
        logic [cwc_pkg::COH_W-1:0]   coh;
        logic [cwc_pkg::COORD_W-1:0] row;
        logic [cwc_pkg::COORD_W-1:0] col;
    } window_result_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we = 1'b0;
    logic [cwc_pkg::CFG_W-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic signed [15:0] cur_real = '0, cur_imag = '0, ref_real = '0, ref_imag = '0;
    logic [cwc_pkg::COORD_W-1:0] window_row = '0, window_col = '0;
    logic last_sample = 1'b0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic [cwc_pkg::COH_W-1:0] coherence;
    logic [cwc_pkg::COORD_W-1:0] center_row, center_col;

    window_result_t pending_results[$];
    logic signed [15:0] held_cr[CAP], held_ci[CAP], held_rr[CAP], held_ri[CAP];
    longint sum_cr, sum_ci, sum_rr, sum_ri;
    int held_count;
    logic [cwc_pkg::CFG_W-1:0] side_len;
    int errors;
    int idle_cycles;
    int send_idle;
    int recv_idle;
    int pairs_sent;

    complex_window_coherence_top u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .cur_real(cur_real), .cur_imag(cur_imag), .ref_real(ref_real), .ref_imag(ref_imag),
        .window_row(window_row), .window_col(window_col), .last_sample(last_sample),
        .out_valid(out_valid), .out_ready(out_ready), .coherence(coherence),
        .center_row(center_row), .center_col(center_col)
    );

    always #5 clk = ~clk;

    function automatic logic [cwc_pkg::COH_W-1:0] window_coherence();
        longint n, cr, ci, pff, pgg, nr, ni, d1, d2, fr, fi, gr, gi;
        logic [255:0] num_sq, den, lhs, mid;
        logic [255:0] lo, hi;
        n = held_count;
        cr = 0; ci = 0; pff = 0; pgg = 0;
        for (int k = 0; k < held_count; k++)
        begin
            fr = held_cr[k]; fi = held_ci[k]; gr = held_rr[k]; gi = held_ri[k];
            pff += fr * fr + fi * fi;
            pgg += gr * gr + gi * gi;
            cr += fr * gr + fi * gi;
            ci += fr * gi - fi * gr;
        end
        nr = n * cr - (sum_cr * sum_rr + sum_ci * sum_ri);
        ni = n * ci - (sum_cr * sum_ri - sum_ci * sum_rr);
        d1 = n * pff - (sum_cr * sum_cr + sum_ci * sum_ci);
        d2 = n * pgg - (sum_rr * sum_rr + sum_ri * sum_ri);
        if (d1 == 0 || d2 == 0)
            return '0;
        if (nr < 0) nr = -nr;
        if (ni < 0) ni = -ni;
        num_sq = (256'(nr) * 256'(nr) + 256'(ni) * 256'(ni)) << cwc_pkg::UNITY_SHIFT;
        den = 256'(d1) * 256'(d2);
        lo = 0;
        hi = 32768;
        while (lo < hi)
        begin
            mid = (lo + hi + 1) >> 1;
            lhs = mid * mid * den;
            if (lhs <= num_sq)
                lo = mid;
            else
                hi = mid - 1;
        end
        return lo[cwc_pkg::COH_W-1:0];
    endfunction

    task automatic absorb_pair(input logic signed [15:0] cr, ci, rr, ri,
                               input logic [cwc_pkg::COORD_W-1:0] row, col,
                               input logic last);
        window_result_t r;
        if (held_count < CAP)
        begin
            held_cr[held_count] = cr; held_ci[held_count] = ci;
            held_rr[held_count] = rr; held_ri[held_count] = ri;
            sum_cr += cr; sum_ci += ci; sum_rr += rr; sum_ri += ri;
            held_count++;
        end
        if (last)
        begin
            r.coh = window_coherence();
            r.row = row + cwc_pkg::COORD_W'(side_len >> 1);
            r.col = col + cwc_pkg::COORD_W'(side_len >> 1);
            pending_results.push_back(r);
            sum_cr = 0; sum_ci = 0; sum_rr = 0; sum_ri = 0;
            held_count = 0;
        end
    endtask

    task automatic send_pair(input logic signed [15:0] cr, ci, rr, ri,
                             input logic [cwc_pkg::COORD_W-1:0] row, col,
                             input logic last);
        while ($urandom_range(99) < send_idle)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        cur_real <= cr; cur_imag <= ci; ref_real <= rr; ref_imag <= ri;
        window_row <= row; window_col <= col; last_sample <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        absorb_pair(cr, ci, rr, ri, row, col, last);
        pairs_sent++;
    endtask

    function automatic logic signed [15:0] pick_value(input int style);
        case (style)
            1: case ($urandom_range(4))
                   0: return -16'sd32768;
                   1: return 16'sd32767;
                   2: return 16'sd0;
                   3: return -16'sd1;
                   default: return 16'sd1;
               endcase
            2: return 16'sd1234;
            default: return 16'($urandom);
        endcase
    endfunction

    // style: 0 random, 1 extremes, 2 constant, 3 ref equals cur, 4 ref bitwise inverted, 5 noisy half-scale copy
    task automatic send_window(input int n, input int style,
                               input logic [cwc_pkg::COORD_W-1:0] row, col);
        logic signed [15:0] a, b, c, d;
        for (int i = 0; i < n; i++)
        begin
            a = pick_value(style);
            b = pick_value(style);
            c = pick_value(style);
            d = pick_value(style);
            if (style == 3)
            begin
                c = a; d = b;
            end
            else if (style == 4)
            begin
                c = ~a; d = ~b;
            end
            else if (style == 5)
            begin
                c = (a >>> 1) + $signed(16'($urandom_range(0, 511)) - 16'sd256);
                d = (b >>> 1) + $signed(16'($urandom_range(0, 511)) - 16'sd256);
            end
            send_pair(a, b, c, d, row, col, i == n - 1);
        end
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
    endtask

    task automatic set_window_size(input logic [cwc_pkg::CFG_W-1:0] v);
        wait_drained();
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        side_len = v;
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch in %s: got %0d, want %0d", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
        out_ready <= rst_n && ($urandom_range(99) >= recv_idle);

    always @(posedge clk)
    begin
        window_result_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $display("unexpected result: coherence %0d", coherence);
                errors++;
            end
            else
            begin
                w = pending_results.pop_front();
                if (coherence !== w.coh) report_mismatch("coherence", coherence, w.coh);
                if (center_row !== w.row) report_mismatch("center_row", center_row, w.row);
                if (center_col !== w.col) report_mismatch("center_col", center_col, w.col);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 30000)
        begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    task automatic test_zero_energy();
        send_window(1, 0, 12'd10, 12'd20);
        send_window(4, 2, 12'd0, 12'd0);
    endtask

    task automatic test_extreme_values();
        send_window(6, 1, 12'd4095, 12'd4095);
        send_pair(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767, 12'd1, 12'd2, 1'b0);
        send_pair(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768, 12'd3, 12'd4, 1'b1);
    endtask

    task automatic test_unity_and_anti();
        send_window(3, 3, 12'd100, 12'd200);
        send_window(3, 4, 12'd300, 12'd400);
    endtask

    task automatic test_window_sizes();
        set_window_size(4'd9);
        send_window(2, 0, 12'd4094, 12'd4090);
        set_window_size(4'd0);
        send_window(2, 0, 12'd7, 12'd8);
        set_window_size(4'd15);
        send_window(2, 5, 12'd4095, 12'd4088);
        set_window_size(4'd4);
        send_window(1, 0, 12'd50, 12'd60);
    endtask

    task automatic test_random(input int target);
        int n, style, windows;
        windows = 0;
        while (pairs_sent < target)
        begin
            if (windows % 12 == 11)
                set_window_size(4'($urandom_range(0, 15)));
            case ($urandom_range(49))
                0: n = $urandom_range(82, 90);
                1, 2, 3: n = CAP;
                4, 5, 6, 7, 8: n = $urandom_range(26, 60);
                default: n = $urandom_range(1, 25);
            endcase
            style = $urandom_range(9);
            if (style > 5) style = 0;
            send_window(n, style, 12'($urandom), 12'($urandom));
            windows++;
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        errors = 0;
        idle_cycles = 0;
        pairs_sent = 0;
        held_count = 0;
        sum_cr = 0; sum_ci = 0; sum_rr = 0; sum_ri = 0;
        side_len = cwc_pkg::WINDOW_RESET;
        send_idle = 21;
        recv_idle = 79;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_zero_energy();
        test_extreme_values();
        test_unity_and_anti();
        test_window_sizes();
        set_window_size(4'd1);
        test_random(650);
        send_idle = 79;
        recv_idle = 21;
        set_window_size(4'd9);
        test_random(1300);
        send_idle = 0;
        recv_idle = 0;
        set_window_size(4'd5);
        test_random(1920);
        wait_drained();
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== sim.f =====
src/cwc_pkg.sv
src/cwc_ram.sv
src/cwc_mac.sv
src/cwc_datapath.sv
src/cwc_ctrl.sv
src/complex_window_coherence_top.sv
src/complex_window_coherence_chk.sv
tb/tb_top.sv
